### rtl/gn3d_pkg.sv
// ----------------------------------------------------------------------------
// gn3d_pkg
// Shared types and constants for the 3D gradient noise block: command and
// register codes, reset values and the input and result beat structs.
// ----------------------------------------------------------------------------
package gn3d_pkg;

  // default permutation and gradient table depth
  localparam int TBL_DEPTH_DEF = 256;

  // command codes
  localparam logic [1:0] CMD_LOAD_PERM = 2'd0;
  localparam logic [1:0] CMD_LOAD_GRAD = 2'd1;
  localparam logic [1:0] CMD_EVAL      = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FREQ_X      = 2'd0;
  localparam logic [1:0] REG_FREQ_Y      = 2'd1;
  localparam logic [1:0] REG_FREQ_Z      = 2'd2;
  localparam logic [1:0] REG_NOISE_SCALE = 2'd3;

  // register reset values
  localparam logic [15:0] FREQ_RESET  = 16'd256;
  localparam logic [15:0] SCALE_RESET = 16'd4096;

  // 3 * 2^16 term of the fade polynomial
  localparam logic [17:0] FADE_THREE = 18'd196608;

  // one half in Q1.14
  localparam logic signed [16:0] NOISE_HALF = 17'sd8192;

  typedef struct packed {
    logic [1:0]          command;
    logic [7:0]          table_index;
    logic [7:0]          perm_value;
    logic signed [15:0]  grad_x;
    logic signed [15:0]  grad_y;
    logic signed [15:0]  grad_z;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  point_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0]  noise_value;
    logic signed [23:0]  blend_weight;
  } out_t;

endpackage

### rtl/gradient_noise_3d.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d
// 3D Perlin gradient noise with loadable permutation and gradient tables.
// ----------------------------------------------------------------------------
// Takes one beat per cycle and returns one result beat per evaluate command
// from the output register. The rate is set by the pipeline itself:
// every table level has its own copies of the permutation and gradient tables
// (one copy for the x level, two for y, four for z and four gradient copies),
// each read at two addresses a cycle, so the eight corner lookups never share
// a port. Loads write every copy as the load passes the stage that reads it,
// so loads and evaluations keep their order. The whole pipeline holds only
// while a finished result waits at the output. Tables read as garbage until
// written; there is no clearing pass.
module gradient_noise_3d #(
  parameter int TBL_DEPTH = gn3d_pkg::TBL_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gn3d_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gn3d_pkg::out_t  out_data,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_addr,
  input  logic [15:0]     cfg_wdata
);

  localparam int IW = $clog2(TBL_DEPTH);

  // configuration registers
  logic signed [15:0] freq_x, freq_y, freq_z;
  logic [15:0]        noise_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_x      <= gn3d_pkg::FREQ_RESET;
      freq_y      <= gn3d_pkg::FREQ_RESET;
      freq_z      <= gn3d_pkg::FREQ_RESET;
      noise_scale <= gn3d_pkg::SCALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        gn3d_pkg::REG_FREQ_X:      freq_x      <= cfg_wdata;
        gn3d_pkg::REG_FREQ_Y:      freq_y      <= cfg_wdata;
        gn3d_pkg::REG_FREQ_Z:      freq_z      <= cfg_wdata;
        gn3d_pkg::REG_NOISE_SCALE: noise_scale <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output beat is held
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: capture, scale point by frequency
  logic                v1, wok1;
  logic [1:0]          cmd1;
  logic [IW-1:0]       widx1;
  logic [7:0]          pval1;
  logic [47:0]         grad1;
  logic signed [47:0]  prod1 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1     <= in_data.command;
      widx1    <= IW'(in_data.table_index);
      wok1     <= (32'(in_data.table_index) < TBL_DEPTH);
      pval1    <= in_data.perm_value;
      grad1    <= {in_data.grad_x, in_data.grad_y, in_data.grad_z};
      prod1[0] <= in_data.point_x * freq_x;
      prod1[1] <= in_data.point_y * freq_y;
      prod1[2] <= in_data.point_z * freq_z;
    end
  end

  // stage 2: cell split, square of fraction, x level lookup
  logic [IW-1:0] cx0_1, cx1_1;
  assign cx0_1 = prod1[0][24 +: IW];
  assign cx1_1 = cx0_1 + IW'(1);

  logic                v2, wok2;
  logic [1:0]          cmd2;
  logic [IW-1:0]       widx2;
  logic [7:0]          pval2;
  logic [47:0]         grad2;
  logic [IW-1:0]       cy_2, cz_2;
  logic [15:0]         t_2 [3];
  logic [31:0]         sq_2 [3];
  logic [7:0]          a2 [2];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2  <= cmd1;
      widx2 <= widx1;
      wok2  <= wok1;
      pval2 <= pval1;
      grad2 <= grad1;
      cy_2  <= prod1[1][24 +: IW];
      cz_2  <= prod1[2][24 +: IW];
      for (int k = 0; k < 3; k++) begin
        t_2[k]  <= prod1[k][23:8];
        sq_2[k] <= prod1[k][23:8] * prod1[k][23:8];
      end
    end
  end

  // x level permutation copy
  logic [7:0] perm_l1 [TBL_DEPTH];
  always_ff @(posedge clk) begin
    if (en) begin
      if (v1 && cmd1 == gn3d_pkg::CMD_LOAD_PERM && wok1) perm_l1[widx1] <= pval1;
      a2[0] <= perm_l1[cx0_1];
      a2[1] <= perm_l1[cx1_1];
    end
  end

  // stage 3: y level lookup, fade square
  logic [IW-1:0] cy1_2;
  assign cy1_2 = cy_2 + IW'(1);

  logic                v3, wok3;
  logic [1:0]          cmd3;
  logic [IW-1:0]       widx3;
  logic [7:0]          pval3;
  logic [47:0]         grad3;
  logic [IW-1:0]       cz_3;
  logic [15:0]         t_3 [3];
  logic [15:0]         sq_3 [3];
  logic [7:0]          b3 [2][2];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd3  <= cmd2;
      widx3 <= widx2;
      wok3  <= wok2;
      pval3 <= pval2;
      grad3 <= grad2;
      cz_3  <= cz_2;
      for (int k = 0; k < 3; k++) begin
        t_3[k]  <= t_2[k];
        sq_3[k] <= sq_2[k][31:16];
      end
    end
  end

  for (genvar gx = 0; gx < 2; gx++) begin : g_perm_l2
    logic [7:0]    mem [TBL_DEPTH];
    logic [IW-1:0] ad0, ad1;
    assign ad0 = IW'(a2[gx]) + cy_2;
    assign ad1 = IW'(a2[gx]) + cy1_2;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v2 && cmd2 == gn3d_pkg::CMD_LOAD_PERM && wok2) mem[widx2] <= pval2;
        b3[gx][0] <= mem[ad0];
        b3[gx][1] <= mem[ad1];
      end
    end
  end

  // stage 4: z level lookup, fade product
  logic [IW-1:0] cz1_3;
  assign cz1_3 = cz_3 + IW'(1);

  logic                v4, wok4;
  logic [1:0]          cmd4;
  logic [IW-1:0]       widx4;
  logic [47:0]         grad4;
  logic [15:0]         t_4 [3];
  logic [33:0]         fp_4 [3];
  logic [7:0]          h4 [4][2];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd4  <= cmd3;
      widx4 <= widx3;
      wok4  <= wok3;
      grad4 <= grad3;
      for (int k = 0; k < 3; k++) begin
        t_4[k]  <= t_3[k];
        fp_4[k] <= sq_3[k] * (gn3d_pkg::FADE_THREE - 18'({t_3[k], 1'b0}));
      end
    end
  end

  for (genvar gxy = 0; gxy < 4; gxy++) begin : g_perm_l3
    logic [7:0]    mem [TBL_DEPTH];
    logic [IW-1:0] ad0, ad1;
    assign ad0 = IW'(b3[gxy / 2][gxy % 2]) + cz_3;
    assign ad1 = IW'(b3[gxy / 2][gxy % 2]) + cz1_3;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v3 && cmd3 == gn3d_pkg::CMD_LOAD_PERM && wok3) mem[widx3] <= pval3;
        h4[gxy][0] <= mem[ad0];
        h4[gxy][1] <= mem[ad1];
      end
    end
  end

  // eval valid chain from stage 5 to the output register
  logic [19:5] ev;
  always_ff @(posedge clk) begin
    if (rst) ev <= '0;
    else if (en) ev <= {ev[18:5], v4 && cmd4 == gn3d_pkg::CMD_EVAL};
  end
  assign out_valid = ev[19];

  // stage 5: gradient lookup, fade done
  logic [15:0] t_5 [3];
  logic [15:0] fd_5 [3];
  logic [47:0] g5 [8];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t_5[k]  <= t_4[k];
        fd_5[k] <= fp_4[k][31:16];
      end
    end
  end

  for (genvar gxy = 0; gxy < 4; gxy++) begin : g_grad
    logic [47:0] mem [TBL_DEPTH];
    always_ff @(posedge clk) begin
      if (en) begin
        if (v4 && cmd4 == gn3d_pkg::CMD_LOAD_GRAD && wok4) mem[widx4] <= grad4;
        g5[gxy * 2]     <= mem[IW'(h4[gxy][0])];
        g5[gxy * 2 + 1] <= mem[IW'(h4[gxy][1])];
      end
    end
  end

  // fade weights ride along to their lerp level
  logic [15:0] fdd [6:14][3];
  always_ff @(posedge clk) begin
    if (en) begin
      fdd[6] <= fd_5;
      for (int k = 7; k <= 14; k++) fdd[k] <= fdd[k - 1];
    end
  end

  // stage 6: corner gradient times offset, per component
  logic signed [32:0] pr6 [8][3];
  for (genvar c = 0; c < 8; c++) begin : g_dot
    localparam int XB = (c / 4) % 2;
    localparam int YB = (c / 2) % 2;
    localparam int ZB = c % 2;
    logic signed [16:0] dx, dy, dz;
    assign dx = {1'(XB), t_5[0]};
    assign dy = {1'(YB), t_5[1]};
    assign dz = {1'(ZB), t_5[2]};
    always_ff @(posedge clk) begin
      if (en) begin
        pr6[c][0] <= $signed(g5[c][47:32]) * dx;
        pr6[c][1] <= $signed(g5[c][31:16]) * dy;
        pr6[c][2] <= $signed(g5[c][15:0]) * dz;
      end
    end
  end

  // stage 7: corner dot products
  logic signed [34:0] dot7 [8];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 8; c++)
        dot7[c] <= 35'(pr6[c][0]) + 35'(pr6[c][1]) + 35'(pr6[c][2]);
    end
  end

  // lerp along x: stages 8 to 10
  logic signed [34:0] la1 [4], lb1 [4], r1 [4];
  logic signed [35:0] da1 [4];
  logic signed [34:0] ph1 [4];
  logic [33:0]        pl1 [4];
  logic signed [52:0] s1 [4];

  always_comb begin
    for (int j = 0; j < 4; j++) s1[j] = (53'(ph1[j]) <<< 18) + 53'(pl1[j]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        la1[j] <= dot7[j];
        da1[j] <= 36'(dot7[4 + j]) - 36'(dot7[j]);
        lb1[j] <= la1[j];
        ph1[j] <= $signed(da1[j][35:18]) * $signed({1'b0, fdd[8][0]});
        pl1[j] <= da1[j][17:0] * fdd[8][0];
        r1[j]  <= lb1[j] + 35'(s1[j] >>> 16);
      end
    end
  end

  // lerp along y: stages 11 to 13
  logic signed [34:0] la2 [2], lb2 [2], r2 [2];
  logic signed [35:0] da2 [2];
  logic signed [34:0] ph2 [2];
  logic [33:0]        pl2 [2];
  logic signed [52:0] s2 [2];

  always_comb begin
    for (int j = 0; j < 2; j++) s2[j] = (53'(ph2[j]) <<< 18) + 53'(pl2[j]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        la2[j] <= r1[j];
        da2[j] <= 36'(r1[2 + j]) - 36'(r1[j]);
        lb2[j] <= la2[j];
        ph2[j] <= $signed(da2[j][35:18]) * $signed({1'b0, fdd[11][1]});
        pl2[j] <= da2[j][17:0] * fdd[11][1];
        r2[j]  <= lb2[j] + 35'(s2[j] >>> 16);
      end
    end
  end

  // lerp along z: stages 14 to 16
  logic signed [34:0] la3, lb3, r3;
  logic signed [35:0] da3;
  logic signed [34:0] ph3;
  logic [33:0]        pl3;
  logic signed [52:0] s3;

  assign s3 = (53'(ph3) <<< 18) + 53'(pl3);

  always_ff @(posedge clk) begin
    if (en) begin
      la3 <= r2[0];
      da3 <= 36'(r2[1]) - 36'(r2[0]);
      lb3 <= la3;
      ph3 <= $signed(da3[35:18]) * $signed({1'b0, fdd[14][2]});
      pl3 <= da3[17:0] * fdd[14][2];
      r3  <= lb3 + 35'(s3 >>> 16);
    end
  end

  // stage 17: drop to Q1.14 and saturate
  logic signed [18:0] nz;
  logic signed [15:0] noise17, noise18, noise19;
  assign nz = r3[34:16];

  always_ff @(posedge clk) begin
    if (en) begin
      if (nz > 19'sd32767)       noise17 <= 16'sh7FFF;
      else if (nz < -19'sd32768) noise17 <= 16'sh8000;
      else                       noise17 <= nz[15:0];
    end
  end

  // stage 18: offset by one half and scale
  logic signed [33:0] wp18;
  always_ff @(posedge clk) begin
    if (en) begin
      noise18 <= noise17;
      wp18    <= (17'(noise17) + gn3d_pkg::NOISE_HALF) * $signed({1'b0, noise_scale});
    end
  end

  // stage 19: output register; the scaled weight always fits 24 bits
  logic signed [23:0] wt19;
  always_ff @(posedge clk) begin
    if (en) begin
      noise19 <= noise18;
      wt19    <= wp18[33:10];
    end
  end

  assign out_data.noise_value  = noise19;
  assign out_data.blend_weight = wt19;

endmodule

### rtl/gn3d_check.sv
// ----------------------------------------------------------------------------
// gn3d_check
// Port-level checks for the gradient noise block, bound to the top level.
// ----------------------------------------------------------------------------
module gn3d_check (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input gn3d_pkg::out_t out_data
);

  // a held result beat stays put
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // input only stalls behind a held result
  assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with output free");

  // weight is never negative when noise is at or above minus one half
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.noise_value >= -16'sd8192) |-> !out_data.blend_weight[23])
    else $error("blend weight sign disagrees with noise");

endmodule

bind gradient_noise_3d gn3d_check u_gn3d_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
